// ----- src/assert_macros.svh -----
// Assertion macros shared by the RTL of the Tamura-Nei matrix block.
// No dependencies; ASSERT_OFF compiles every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

// ----- src/tnm_pkg.sv -----
// Shared types, constants and the exp(-1) constant for the Tamura-Nei block.
// No dependencies.
package tnm_pkg;

	localparam int NUM_BASES  = 4;
	localparam int MATRIX_LEN = NUM_BASES * NUM_BASES;
	localparam int FRAC_BITS  = 16;
	localparam int FREQ_W     = 16;
	localparam int PROB_W     = FRAC_BITS + 1;   // holds 1.0 exactly
	localparam int EXP_TERMS  = 12;              // Horner terms of exp(-f)
	localparam int PWR_STAGES = 22;              // exp(-1)^n steps, n < 23
	localparam int EXP_ZERO_N = PWR_STAGES + 1;  // n at which exp underflows
	localparam int EXP_OPS    = 5;
	localparam int X_W        = 33;              // rate*d in Q9.24 (17x16 bits)
	localparam int NUM_W      = 33;              // within-group dividend
	localparam int DEN_W      = FREQ_W + 1;      // group frequency sum
	localparam int QUO_W      = PROB_W;
	localparam int DIV_PER_STAGE = 2;
	localparam int DIV_STAGES = (QUO_W + DIV_PER_STAGE - 1) / DIV_PER_STAGE;

	typedef logic [PROB_W-1:0] prob_t;
	typedef logic [NUM_BASES-1:0][FREQ_W-1:0] freq_vec_t;

	localparam prob_t ONE_PROB = prob_t'(1) << FRAC_BITS;

	typedef enum logic [2:0] {
		EXP_BETA = 3'd0,  // beta*d
		EXP_IPUR = 3'd1,  // alpha_R*d
		EXP_IPYR = 3'd2,  // alpha_Y*d
		EXP_APUR = 3'd3,  // (alpha_R+beta)*d
		EXP_APYR = 3'd4   // (alpha_Y+beta)*d
	} exp_op_t;

	typedef struct packed {
		logic           valid;
		exp_op_t        op;
		logic [X_W-1:0] x;
		freq_vec_t      freq;
	} exp_req_t;

	typedef struct packed {
		logic      valid;
		exp_op_t   op;
		prob_t     e;
		freq_vec_t freq;
	} exp_rsp_t;

	typedef struct packed {
		logic             valid;
		logic [1:0]       col;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
		logic             zero;
		prob_t            bg;
		prob_t [1:0]      ea;
	} div_req_t;

	typedef struct packed {
		logic        valid;
		logic [1:0]  col;
		prob_t       quo;
		logic        zero;
		prob_t       bg;
		prob_t [1:0] ea;
	} div_rsp_t;

	// exp(-1) in Q0.32: truncated square of the Horner series at f = 1/2
	function automatic logic [31:0] calc_exp_m1();
		logic [63:0] p;
		logic [63:0] f;
		logic [63:0] h;
		p = 64'd1 << 32;
		f = 64'd1 << 31;
		for (int k = EXP_TERMS; k >= 1; k--) begin
			p = (64'd1 << 32) - ((f * p) >> 32) / 64'(k);
		end
		h = p;
		return 32'((h * h) >> 32);
	endfunction

	localparam logic [31:0] EXP_M1 = calc_exp_m1();

endpackage

// ----- src/tamura_nei_transition_matrix.sv -----
// Top level of the Tamura-Nei transition probability matrix block.
// Depends on tnm_pkg, tnm_exp, tnm_div and assert_macros.svh.
//
//  channel   handshake          payload
//  request   start / busy       branch_length, freq_a..freq_t, rate_*
//  result    strobe (no stall)  from_base, to_base, probability,
//                               group_zero_flag, last_entry
//
// A request is taken when start is high and busy is low. busy then stays
// high until the issue counter reaches ISSUE_LAST, so requests are spaced
// to fit the single result port (one matrix entry per cycle).
// The 16 entries come out row-major on consecutive cycles; the exp pipeline
// (60 stages) dominates the delay from the accepting edge to the first strobe.
// arst_n clears all valid bits and sequencers; data registers are not reset.
// The receiver cannot stall, so the pipeline never holds.
`include "assert_macros.svh"

module tamura_nei_transition_matrix import tnm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [15:0] branch_length,
	input  logic [15:0] freq_a,
	input  logic [15:0] freq_c,
	input  logic [15:0] freq_g,
	input  logic [15:0] freq_t,
	input  logic [15:0] rate_purine,
	input  logic [15:0] rate_pyrimidine,
	input  logic [15:0] rate_transversion,
	output logic        strobe,
	output logic [1:0]  from_base,
	output logic [1:0]  to_base,
	output logic [15:0] probability,
	output logic        group_zero_flag,
	output logic        last_entry
);

	localparam logic [3:0] ISSUE_LAST = 4'(MATRIX_LEN - 2);
	localparam logic [3:0] ENTRY_LAST = 4'(MATRIX_LEN - 1);
	localparam logic [1:0] COL_LAST   = 2'(NUM_BASES - 1);

	// ---------------------------------------------------------------
	// Request capture and issue of the five exponentials
	// ---------------------------------------------------------------
	logic        accept;
	logic        iss_act_q;
	logic [3:0]  iss_cnt_q;
	logic [15:0] d_q;
	logic [15:0] pur_q;
	logic [15:0] pyr_q;
	logic [15:0] beta_q;
	freq_vec_t   freq_q;
	exp_op_t     iss_op;
	logic [16:0] iss_rate;
	exp_req_t    exp_req;
	exp_rsp_t    exp_rsp;

	assign accept = start && !busy;
	assign busy   = iss_act_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_act_q <= 1'b0;
			iss_cnt_q <= '0;
		end else if (accept) begin
			iss_act_q <= 1'b1;
			iss_cnt_q <= '0;
		end else if (iss_act_q) begin
			iss_cnt_q <= iss_cnt_q + 4'd1;
			if (iss_cnt_q == ISSUE_LAST) begin
				iss_act_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			d_q    <= branch_length;
			pur_q  <= rate_purine;
			pyr_q  <= rate_pyrimidine;
			beta_q <= rate_transversion;
			freq_q <= {freq_t, freq_g, freq_c, freq_a};
		end
	end

	assign iss_op = exp_op_t'(iss_cnt_q[2:0]);

	always_comb begin
		unique case (iss_op)
			EXP_BETA: iss_rate = {1'b0, beta_q};
			EXP_IPUR: iss_rate = {1'b0, pur_q};
			EXP_IPYR: iss_rate = {1'b0, pyr_q};
			EXP_APUR: iss_rate = 17'(pur_q) + 17'(beta_q);
			EXP_APYR: iss_rate = 17'(pyr_q) + 17'(beta_q);
			default:  iss_rate = '0;
		endcase
	end

	assign exp_req.valid = iss_act_q && (iss_cnt_q < 4'(EXP_OPS));
	assign exp_req.op    = iss_op;
	assign exp_req.x     = X_W'(iss_rate) * X_W'(d_q);
	assign exp_req.freq  = freq_q;

	tnm_exp u_exp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (exp_req),
		.rsp    (exp_rsp)
	);

	// ---------------------------------------------------------------
	// Gather exponentials; the last one launches the four column terms
	// ---------------------------------------------------------------
	prob_t       eb_q;
	prob_t [1:0] ei_q;
	prob_t       ea_pur_q;
	prob_t       c_eb_q;
	prob_t [1:0] c_ei_q;
	prob_t [1:0] c_ea_q;
	freq_vec_t   c_freq_q;
	logic        c_act_q;
	logic [1:0]  c_cnt_q;
	logic        c_launch;

	assign c_launch = exp_rsp.valid && (exp_rsp.op == EXP_APYR);

	always_ff @(posedge clk) begin
		if (exp_rsp.valid) begin
			case (exp_rsp.op)
				EXP_BETA: eb_q     <= exp_rsp.e;
				EXP_IPUR: ei_q[0]  <= exp_rsp.e;
				EXP_IPYR: ei_q[1]  <= exp_rsp.e;
				EXP_APUR: ea_pur_q <= exp_rsp.e;
				EXP_APYR: begin
					c_eb_q   <= eb_q;
					c_ei_q   <= ei_q;
					c_ea_q   <= {exp_rsp.e, ea_pur_q};
					c_freq_q <= exp_rsp.freq;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_act_q <= 1'b0;
			c_cnt_q <= '0;
		end else if (c_launch) begin
			c_act_q <= 1'b1;
			c_cnt_q <= '0;
		end else if (c_act_q) begin
			c_cnt_q <= c_cnt_q + 2'd1;
			if (c_cnt_q == COL_LAST) begin
				c_act_q <= 1'b0;
			end
		end
	end

	// column stage 1: eb*(1-ei), background term, group sum
	logic [FREQ_W-1:0] c_pi;
	logic [DEN_W-1:0]  c_den;
	prob_t             c_one_m_ei;
	prob_t             c_one_m_eb;
	logic [32:0]       c_bg_prod;
	logic              vld_s1;
	logic [1:0]        col_s1;
	logic [33:0]       prod_s1;
	logic [FREQ_W-1:0] pi_s1;
	logic [DEN_W-1:0]  den_s1;
	prob_t             bg_s1;
	prob_t [1:0]       ea_s1;

	assign c_pi       = c_freq_q[c_cnt_q];
	assign c_den      = DEN_W'(c_pi) + DEN_W'(c_freq_q[c_cnt_q ^ 2'd2]);
	assign c_one_m_ei = ONE_PROB - c_ei_q[c_cnt_q[0]];
	assign c_one_m_eb = ONE_PROB - c_eb_q;
	assign c_bg_prod  = 33'(c_one_m_eb) * 33'(c_pi);

	// column stage 2: times pi_j, dropping the Q0.16 fraction
	logic              vld_s2;
	logic [49:0]       num_prod;
	logic [1:0]        col_s2;
	logic [NUM_W-1:0]  num_s2;
	logic [DEN_W-1:0]  den_s2;
	logic              zero_s2;
	prob_t             bg_s2;
	prob_t [1:0]       ea_s2;
	div_req_t          div_req;
	div_rsp_t          div_rsp;

	assign num_prod = 50'(prod_s1) * 50'(pi_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= c_act_q;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		col_s1  <= c_cnt_q;
		prod_s1 <= 34'(c_eb_q) * 34'(c_one_m_ei);
		pi_s1   <= c_pi;
		den_s1  <= c_den;
		bg_s1   <= c_bg_prod[32:16];
		ea_s1   <= c_ea_q;
		col_s2  <= col_s1;
		num_s2  <= num_prod[48:16];
		den_s2  <= den_s1;
		zero_s2 <= (den_s1 == '0);
		bg_s2   <= bg_s1;
		ea_s2   <= ea_s1;
	end

	assign div_req.valid = vld_s2;
	assign div_req.col   = col_s2;
	assign div_req.num   = num_s2;
	assign div_req.den   = den_s2;
	assign div_req.zero  = zero_s2;
	assign div_req.bg    = bg_s2;
	assign div_req.ea    = ea_s2;

	tnm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// ---------------------------------------------------------------
	// Gather column terms; the last column launches the 16 entries
	// ---------------------------------------------------------------
	prob_t [2:0] wt_q;
	prob_t [2:0] bg_q;
	logic  [2:0] fl_q;
	prob_t [3:0] o_wt_q;
	prob_t [3:0] o_bg_q;
	logic  [3:0] o_fl_q;
	prob_t [1:0] o_ea_q;
	logic        o_act_q;
	logic [3:0]  o_cnt_q;
	logic        o_launch;

	assign o_launch = div_rsp.valid && (div_rsp.col == COL_LAST);

	always_ff @(posedge clk) begin
		if (div_rsp.valid) begin
			if (div_rsp.col == COL_LAST) begin
				o_wt_q <= {div_rsp.quo, wt_q};
				o_bg_q <= {div_rsp.bg, bg_q};
				o_fl_q <= {div_rsp.zero, fl_q};
				o_ea_q <= div_rsp.ea;
			end else begin
				wt_q[div_rsp.col] <= div_rsp.quo;
				bg_q[div_rsp.col] <= div_rsp.bg;
				fl_q[div_rsp.col] <= div_rsp.zero;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_act_q <= 1'b0;
			o_cnt_q <= '0;
		end else if (o_launch) begin
			o_act_q <= 1'b1;
			o_cnt_q <= '0;
		end else if (o_act_q) begin
			o_cnt_q <= o_cnt_q + 4'd1;
			if (o_cnt_q == ENTRY_LAST) begin
				o_act_q <= 1'b0;
			end
		end
	end

	// entry (i,j) = decay on the diagonal + within-group + background
	logic [1:0]  row;
	logic [1:0]  col;
	logic [18:0] sum;

	assign row = o_cnt_q[3:2];
	assign col = o_cnt_q[1:0];
	assign sum = 19'(o_bg_q[col])
		+ ((row[0] == col[0]) ? 19'(o_wt_q[col]) : 19'd0)
		+ ((row == col) ? 19'(o_ea_q[row[0]]) : 19'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe <= 1'b0;
		end else begin
			strobe <= o_act_q;
		end
	end

	always_ff @(posedge clk) begin
		from_base       <= row;
		to_base         <= col;
		probability     <= (sum > 19'(16'hFFFF)) ? 16'hFFFF : sum[15:0];
		group_zero_flag <= o_fl_q[col];
		last_entry      <= (o_cnt_q == ENTRY_LAST);
	end

	logic mat_end;
	logic at_aa;
	logic at_tt;

	assign mat_end = strobe && last_entry;
	assign at_aa   = (from_base == 2'd0) && (to_base == 2'd0);
	assign at_tt   = (from_base == 2'd3) && (to_base == 2'd3);

	`ASSERT_CLK(a_busy_after_accept, clk, arst_n, accept |=> busy, "busy not raised")
	`ASSERT_CLK(a_matrix_contiguous, clk, arst_n, strobe && !last_entry |=> strobe, "gap in matrix")
	`ASSERT_CLK(a_next_start, clk, arst_n, mat_end |=> !strobe || at_aa, "no restart at A,A")
	`ASSERT_NEVER(a_last_is_tt, clk, arst_n, mat_end && !at_tt, "last entry is not T,T")

endmodule

// ----- src/tnm_exp.sv -----
// Pipelined exp(-x) unit: x in Q9.24, result in Q0.16 rounded half up.
// Depends on tnm_pkg.
module tnm_exp import tnm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  exp_req_t req,
	output exp_rsp_t rsp
);

	typedef struct packed {
		exp_op_t     op;
		logic [31:0] f;
		logic [4:0]  n;
		logic        zero;
		freq_vec_t   freq;
	} exp_side_t;

	localparam logic [32:0] ONE_P = 33'd1 << 32;
	localparam int RND_SHIFT = 32 - FRAC_BITS;

	logic        vld_s0;
	exp_side_t   side_s0;

	logic        vld_a  [EXP_TERMS];
	logic        vld_b  [EXP_TERMS];
	logic        vld_c  [EXP_TERMS];
	exp_side_t   side_a [EXP_TERMS];
	exp_side_t   side_b [EXP_TERMS];
	exp_side_t   side_c [EXP_TERMS];
	logic [31:0] v_a    [EXP_TERMS];
	logic [31:0] v_b    [EXP_TERMS];
	logic [31:0] q0_b   [EXP_TERMS];
	logic [32:0] p_c    [EXP_TERMS];

	logic        vld_p  [PWR_STAGES];
	exp_side_t   side_p [PWR_STAGES];
	logic [32:0] e_p    [PWR_STAGES];

	logic        vld_r;
	exp_side_t   side_r;
	prob_t       e_r;
	logic [32:0] e_sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s0 <= 1'b0;
		end else begin
			vld_s0 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		side_s0.op   <= req.op;
		side_s0.f    <= {req.x[23:0], 8'd0};
		side_s0.n    <= req.x[28:24];
		side_s0.zero <= (req.x[X_W-1:24] >= 9'(EXP_ZERO_N));
		side_s0.freq <= req.freq;
	end

	// Horner steps p = 1 - f*p/k, k from 12 down to 1; three stages each:
	// product, reciprocal multiply, remainder correction
	for (genvar t = 0; t < EXP_TERMS; t++) begin : g_term
		localparam int K = EXP_TERMS - t;
		localparam logic [35:0] RECIP = 36'((64'd1 << 35) / K);

		logic        vld_in;
		exp_side_t   side_in;
		logic [32:0] p_in;
		logic [64:0] prod_a;
		logic [67:0] prod_b;
		logic [31:0] r_c;
		logic [31:0] q_c;

		if (t == 0) begin : g_first
			assign vld_in  = vld_s0;
			assign side_in = side_s0;
			assign p_in    = ONE_P;
		end else begin : g_next
			assign vld_in  = vld_c[t-1];
			assign side_in = side_c[t-1];
			assign p_in    = p_c[t-1];
		end

		assign prod_a = 65'(side_in.f) * 65'(p_in);
		assign prod_b = 68'(v_a[t]) * 68'(RECIP);
		assign r_c    = v_b[t] - q0_b[t] * 32'(K);
		assign q_c    = (r_c >= 32'(K)) ? q0_b[t] + 32'd1 : q0_b[t];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_a[t] <= 1'b0;
				vld_b[t] <= 1'b0;
				vld_c[t] <= 1'b0;
			end else begin
				vld_a[t] <= vld_in;
				vld_b[t] <= vld_a[t];
				vld_c[t] <= vld_b[t];
			end
		end

		always_ff @(posedge clk) begin
			side_a[t] <= side_in;
			v_a[t]    <= prod_a[63:32];
			side_b[t] <= side_a[t];
			v_b[t]    <= v_a[t];
			q0_b[t]   <= prod_b[66:35];
			side_c[t] <= side_b[t];
			p_c[t]    <= ONE_P - 33'(q_c);
		end
	end

	// integer part: one truncated multiply by exp(-1) per stage while s < n
	for (genvar s = 0; s < PWR_STAGES; s++) begin : g_pwr
		logic        vld_in;
		exp_side_t   side_in;
		logic [32:0] e_in;
		logic [64:0] prod;

		if (s == 0) begin : g_first
			assign vld_in  = vld_c[EXP_TERMS-1];
			assign side_in = side_c[EXP_TERMS-1];
			assign e_in    = p_c[EXP_TERMS-1];
		end else begin : g_next
			assign vld_in  = vld_p[s-1];
			assign side_in = side_p[s-1];
			assign e_in    = e_p[s-1];
		end

		assign prod = 65'(e_in) * 65'(EXP_M1);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_p[s] <= 1'b0;
			end else begin
				vld_p[s] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			side_p[s] <= side_in;
			if (!side_in.zero && side_in.n > 5'(s)) begin
				e_p[s] <= {1'b0, prod[63:32]};
			end else begin
				e_p[s] <= e_in;
			end
		end
	end

	assign e_sum = e_p[PWR_STAGES-1] + (33'd1 << (RND_SHIFT - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_r <= 1'b0;
		end else begin
			vld_r <= vld_p[PWR_STAGES-1];
		end
	end

	always_ff @(posedge clk) begin
		side_r <= side_p[PWR_STAGES-1];
		e_r    <= side_p[PWR_STAGES-1].zero ? '0 : e_sum[32:RND_SHIFT];
	end

	assign rsp.valid = vld_r;
	assign rsp.op    = side_r.op;
	assign rsp.e     = e_r;
	assign rsp.freq  = side_r.freq;

endmodule

// ----- src/tnm_div.sv -----
// Pipelined restoring divider for the within-group term, two quotient bits
// per stage. Depends on tnm_pkg.
module tnm_div import tnm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	typedef struct packed {
		logic [1:0]       col;
		logic [DEN_W-1:0] den;
		logic             zero;
		prob_t            bg;
		prob_t [1:0]      ea;
	} div_side_t;

	logic             vld_d  [DIV_STAGES];
	logic [DEN_W-1:0] rem_d  [DIV_STAGES];
	logic [QUO_W-1:0] dvd_d  [DIV_STAGES];
	logic [QUO_W-1:0] quo_d  [DIV_STAGES];
	div_side_t        side_d [DIV_STAGES];

	for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
		logic             vld_in;
		logic [DEN_W-1:0] rem_in;
		logic [QUO_W-1:0] dvd_in;
		logic [QUO_W-1:0] quo_in;
		div_side_t        side_in;
		logic [DEN_W-1:0] rem;
		logic [QUO_W-1:0] dvd;
		logic [QUO_W-1:0] quo;
		logic [DEN_W:0]   trial;

		if (s == 0) begin : g_first
			// quotient fits QUO_W bits, so the high part is already below den
			assign vld_in       = req.valid;
			assign rem_in       = DEN_W'(req.num[NUM_W-1:QUO_W]);
			assign dvd_in       = req.num[QUO_W-1:0];
			assign quo_in       = '0;
			assign side_in.col  = req.col;
			assign side_in.den  = req.den;
			assign side_in.zero = req.zero;
			assign side_in.bg   = req.bg;
			assign side_in.ea   = req.ea;
		end else begin : g_next
			assign vld_in  = vld_d[s-1];
			assign rem_in  = rem_d[s-1];
			assign dvd_in  = dvd_d[s-1];
			assign quo_in  = quo_d[s-1];
			assign side_in = side_d[s-1];
		end

		always_comb begin
			rem   = rem_in;
			dvd   = dvd_in;
			quo   = quo_in;
			trial = '0;
			for (int u = 0; u < DIV_PER_STAGE; u++) begin
				if (s * DIV_PER_STAGE + u < QUO_W) begin
					trial = {rem, dvd[QUO_W-1]};
					if (trial >= {1'b0, side_in.den}) begin
						rem = DEN_W'(trial - {1'b0, side_in.den});
						quo = {quo[QUO_W-2:0], 1'b1};
					end else begin
						rem = trial[DEN_W-1:0];
						quo = {quo[QUO_W-2:0], 1'b0};
					end
					dvd = {dvd[QUO_W-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_d[s] <= 1'b0;
			end else begin
				vld_d[s] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			rem_d[s]  <= rem;
			dvd_d[s]  <= dvd;
			quo_d[s]  <= quo;
			side_d[s] <= side_in;
		end
	end

	assign rsp.valid = vld_d[DIV_STAGES-1];
	assign rsp.col   = side_d[DIV_STAGES-1].col;
	assign rsp.quo   = side_d[DIV_STAGES-1].zero ? '0 : quo_d[DIV_STAGES-1];
	assign rsp.zero  = side_d[DIV_STAGES-1].zero;
	assign rsp.bg    = side_d[DIV_STAGES-1].bg;
	assign rsp.ea    = side_d[DIV_STAGES-1].ea;

endmodule

// ----- test/tb.sv -----
// Self-checking testbench for tamura_nei_transition_matrix.
// Depends on tnm_pkg and the RTL; the expected matrix is computed in place
// and each strobed entry is checked against the oldest expected one.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import tnm_pkg::NUM_BASES;
	import tnm_pkg::MATRIX_LEN;

	// One request as driven on the ports.
	typedef struct {
		logic [15:0] blen;
		logic [15:0] freq [NUM_BASES];
		logic [15:0] alpha_r;
		logic [15:0] alpha_y;
		logic [15:0] beta;
	} tn_request_t;

	// One matrix entry as it should appear on the result ports.
	typedef struct {
		logic [1:0]  row;
		logic [1:0]  col;
		logic [15:0] prob;
		logic        zero_grp;
		logic        last;
	} tn_entry_t;

	// Holds the expected entries and computes them from each taken request.
	class matrix_scoreboard;
		tn_entry_t pending[$];
		int        errors = 0;

		// exp(-f), f and result in Q0.32, 12-term Horner series
		function automatic logic [63:0] exp_frac(logic [63:0] f);
			logic [63:0] acc;
			acc = 64'd1 << 32;
			for (int k = 12; k >= 1; k--)
				acc = (64'd1 << 32) - ((f * acc) >> 32) / 64'(k);
			return acc;
		endfunction

		// exp(-x) with x in Q9.24, result in Q0.16 rounded half up
		function automatic logic [63:0] exp_decay(logic [63:0] x24);
			logic [63:0] x;
			logic [63:0] whole;
			logic [63:0] e;
			logic [63:0] half;
			logic [63:0] em1;
			x = x24 << 8;
			whole = x >> 32;
			if (whole >= 23)
				return 0;
			e = exp_frac({32'd0, x[31:0]});
			half = exp_frac(64'd1 << 31);
			em1 = (half * half) >> 32;
			for (int k = 0; k < whole; k++)
				e = (e * em1) >> 32;
			return (e + (64'd1 << 15)) >> 16;
		endfunction

		function void note_request(tn_request_t r);
			logic [63:0] unit;
			logic [63:0] grp [2];
			logic [63:0] eb;
			logic [63:0] ea;
			logic [63:0] ei;
			logic [63:0] rate;
			logic [63:0] acc;
			tn_entry_t   ent;
			unit = 64'd1 << 16;
			grp[0] = 64'(r.freq[0]) + 64'(r.freq[2]);
			grp[1] = 64'(r.freq[1]) + 64'(r.freq[3]);
			eb = exp_decay(64'(r.beta) * 64'(r.blen));
			for (int i = 0; i < NUM_BASES; i++) begin
				rate = (i % 2 == 0) ? 64'(r.alpha_r) : 64'(r.alpha_y);
				ea = exp_decay((rate + 64'(r.beta)) * 64'(r.blen));
				ei = exp_decay(rate * 64'(r.blen));
				for (int j = 0; j < NUM_BASES; j++) begin
					acc = 0;
					if (i == j)
						acc += ea;
					// within-group share, skipped when the group is empty
					if ((i % 2) == (j % 2) && grp[j%2] != 0)
						acc += (eb * (unit - ei) * 64'(r.freq[j])) / (grp[j%2] << 16);
					acc += ((unit - eb) * 64'(r.freq[j])) >> 16;
					ent.row = 2'(i);
					ent.col = 2'(j);
					ent.prob = (acc > 65535) ? 16'hFFFF : acc[15:0];
					ent.zero_grp = (grp[j%2] == 0);
					ent.last = (i * NUM_BASES + j == MATRIX_LEN - 1);
					pending.push_back(ent);
				end
			end
		endfunction

		function void check_entry(tn_entry_t got);
			tn_entry_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected entry row %0d col %0d", $time, got.row, got.col);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.row != want.row) begin
				$display("%0t: from_base exp %0d got %0d", $time, want.row, got.row);
				errors++;
			end
			if (got.col != want.col) begin
				$display("%0t: to_base exp %0d got %0d", $time, want.col, got.col);
				errors++;
			end
			if (got.prob != want.prob) begin
				$display("%0t: probability [%0d][%0d] exp %0d got %0d", $time,
					want.row, want.col, want.prob, got.prob);
				errors++;
			end
			if (got.zero_grp != want.zero_grp) begin
				$display("%0t: group_zero_flag exp %0b got %0b", $time,
					want.zero_grp, got.zero_grp);
				errors++;
			end
			if (got.last != want.last) begin
				$display("%0t: last_entry exp %0b got %0b", $time, want.last, got.last);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [15:0] branch_length = '0;
	logic [15:0] freq_a = '0;
	logic [15:0] freq_c = '0;
	logic [15:0] freq_g = '0;
	logic [15:0] freq_t = '0;
	logic [15:0] rate_purine = '0;
	logic [15:0] rate_pyrimidine = '0;
	logic [15:0] rate_transversion = '0;
	logic        strobe;
	logic [1:0]  from_base;
	logic [1:0]  to_base;
	logic [15:0] probability;
	logic        group_zero_flag;
	logic        last_entry;

	matrix_scoreboard sb = new();
	int idle_pct = 0;   // chance per cycle that the sender holds off

	tamura_nei_transition_matrix u_top (.*);

	always #1 clk = ~clk;

	// Results cannot be stalled: every strobe is an accepted entry.
	always @(posedge clk) begin
		tn_entry_t got;
		if (arst_n && strobe) begin
			got.row = from_base;
			got.col = to_base;
			got.prob = probability;
			got.zero_grp = group_zero_flag;
			got.last = last_entry;
			sb.check_entry(got);
		end
	end

	// Present a request and hold it until busy is low at an edge.
	// Random idle cycles come first, with start low.
	task automatic send_request(tn_request_t r);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < idle_pct);
		end
		branch_length <= r.blen;
		freq_a <= r.freq[0];
		freq_c <= r.freq[1];
		freq_g <= r.freq[2];
		freq_t <= r.freq[3];
		rate_purine <= r.alpha_r;
		rate_pyrimidine <= r.alpha_y;
		rate_transversion <= r.beta;
		start <= 1'b1;
		do
			@(posedge clk);
		while (busy);
		sb.note_request(r);
	endtask

	task automatic send_fields(logic [15:0] d, logic [15:0] fa, logic [15:0] fc,
			logic [15:0] fg, logic [15:0] ft, logic [15:0] ar, logic [15:0] ay,
			logic [15:0] b);
		tn_request_t r;
		r.blen = d;
		r.freq[0] = fa;
		r.freq[1] = fc;
		r.freq[2] = fg;
		r.freq[3] = ft;
		r.alpha_r = ar;
		r.alpha_y = ay;
		r.beta = b;
		send_request(r);
	endtask

	// Mostly frequencies that sum to one, some with a group emptied, and rate*distance
	// products below or beyond the point where exponentials go zero; the rest is raw noise.
	task automatic send_random();
		int          kind;
		logic [15:0] f [NUM_BASES];
		int          rest;
		logic [15:0] lim;
		kind = $urandom_range(99);
		if (kind < 20) begin
			send_fields(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
				16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
		end else begin
			rest = 65536;
			for (int k = 0; k < 3; k++) begin
				f[k] = 16'($urandom_range(0, (rest > 65535) ? 65535 : rest));
				rest -= f[k];
			end
			f[3] = (rest > 65535) ? 16'hFFFF : rest[15:0];
			if (kind < 30) begin
				// empty purine or pyrimidine group
				if ($urandom_range(1)) begin
					f[0] = 0; f[2] = 0;
				end else begin
					f[1] = 0; f[3] = 0;
				end
			end
			lim = (kind < 60) ? 16'h1FFF : 16'h7FFF;
			send_fields(16'($urandom_range(0, lim)), f[0], f[1], f[2], f[3],
				16'($urandom_range(0, lim)), 16'($urandom_range(0, lim)),
				16'($urandom_range(0, lim)));
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// directed corners
		send_fields(16'h0000, 16'h4000, 16'h4000, 16'h4000, 16'h4000,
			16'h1000, 16'h1000, 16'h1000);                  // zero distance
		send_fields(16'h1000, 16'h4000, 16'h4000, 16'h4000, 16'h4000,
			16'h1000, 16'h2000, 16'h0800);                  // uniform, d = 1
		send_fields(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
			16'h0000, 16'h0000, 16'h0000);                  // everything zero
		send_fields(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			16'hFFFF, 16'hFFFF, 16'hFFFF);                  // everything max
		send_fields(16'h2000, 16'h0000, 16'h8000, 16'h0000, 16'h8000,
			16'h1800, 16'h0C00, 16'h0400);                  // no purines
		send_fields(16'h2000, 16'h8000, 16'h0000, 16'h8000, 16'h0000,
			16'h1800, 16'h0C00, 16'h0400);                  // no pyrimidines
		send_fields(16'h0800, 16'hFFFF, 16'hFFFF, 16'h0001, 16'h0001,
			16'h3000, 16'h0100, 16'h0200);                  // sums far above one
		send_fields(16'hFFFF, 16'h1000, 16'h5000, 16'h7000, 16'h3000,
			16'h0000, 16'h0000, 16'h0000);                  // zero rates
		send_fields(16'h6000, 16'h1000, 16'h5000, 16'h7000, 16'h3000,
			16'h4000, 16'h4000, 16'h4000);                  // exponentials underflow
		send_fields(16'h5C00, 16'h3000, 16'h5000, 16'h5000, 16'h3000,
			16'h1000, 16'h0000, 16'h0000);                  // n = 5
		send_fields(16'h5C00, 16'h3000, 16'h5000, 16'h5000, 16'h3000,
			16'h0000, 16'h1000, 16'h0FFF);                  // n = 5 and 11
		send_fields(16'h0001, 16'h0001, 16'h0001, 16'h0001, 16'h0001,
			16'h0001, 16'h0001, 16'h0001);                  // smallest nonzero
		send_fields(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA,
			16'h5555, 16'hAAAA, 16'h5555);
		send_fields(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555,
			16'hAAAA, 16'h5555, 16'hAAAA);

		// random requests in three idling phases
		idle_pct = 24;
		repeat (40) send_random();
		idle_pct = 82;
		repeat (40) send_random();
		idle_pct = 0;
		repeat (40) send_random();
		start <= 1'b0;

		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (sb.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// Watchdog far beyond the slowest legal run.
	initial begin
		#2000000;
		$display("== FAIL ==");
		$finish;
	end
endmodule
